FILE: rtl/ucd_pkg.sv
// Shared types and constants for the Unix-seconds to civil date converter.
// Holds the request and response beat structs, the reciprocal constants
// and the month-start table. Depends on nothing.
package ucd_pkg;

   typedef struct packed {
      logic [31:0] unix_seconds;
      logic [9:0]  fraction_ms;
   } ucd_req_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [9:0]  millisecond;
   } ucd_rsp_type;

   // Pipeline depth from accepted request to registered response.
   localparam int unsigned PIPE_STAGES = 9;

   // 86400 = 128 * 675, so the day count is (secs >> 7) / 675.
   localparam int unsigned SECS_PER_DAY = 86400;
   localparam int unsigned DAY_LOW_BITS = 7;
   localparam int unsigned DAY_DIV      = SECS_PER_DAY >> DAY_LOW_BITS;
   localparam int unsigned SECS_PER_MIN = 60;
   localparam int unsigned MINS_PER_HR  = 60;

   // Rounded-up reciprocals. Each shift is chosen so that the product is
   // the exact quotient over the full range of its dividend.
   localparam int unsigned DAY_SHIFT = 35;
   localparam logic [25:0] DAY_RECIP =
      26'(((64'd1 << DAY_SHIFT) + 64'(DAY_DIV) - 64'd1) / 64'(DAY_DIV));

   localparam int unsigned MIN_SHIFT = 19;   // (sod >> 2) / 15
   localparam logic [15:0] MIN_RECIP = 16'(((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15);

   localparam int unsigned HOUR_SHIFT = 13;  // (minutes >> 2) / 15
   localparam logic [9:0]  HOUR_RECIP = 10'(((64'd1 << HOUR_SHIFT) + 64'd14) / 64'd15);

   localparam int unsigned DAYS_PER_YEAR = 365;
   localparam int unsigned Q1460_SHIFT = 25; // (doe >> 2) / 365
   localparam logic [16:0] Q1460_RECIP =
      17'(((64'd1 << Q1460_SHIFT) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));

   localparam int unsigned YOE_SHIFT = 27;   // t / 365
   localparam logic [18:0] YOE_RECIP =
      19'(((64'd1 << YOE_SHIFT) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));

   localparam int unsigned MONTH_LEN_SUM = 153;
   localparam int unsigned MP_SHIFT = 19;    // (5 * doy + 2) / 153
   localparam logic [11:0] MP_RECIP =
      12'(((64'd1 << MP_SHIFT) + 64'(MONTH_LEN_SUM) - 64'd1) / 64'(MONTH_LEN_SUM));

   // Era arithmetic. Every 32-bit input lands in era 4 or era 5.
   localparam logic [19:0] EPOCH_SHIFT   = 20'd719468;
   localparam int unsigned DAYS_PER_ERA  = 146097;
   localparam logic [19:0] ERA4_START    = 20'(4 * DAYS_PER_ERA);
   localparam logic [19:0] ERA5_START    = 20'(5 * DAYS_PER_ERA);
   localparam logic [11:0] ERA4_YEAR     = 12'd1600;
   localparam logic [11:0] ERA5_YEAR     = 12'd2000;
   localparam int unsigned CENTURY_DAYS  = 36524;
   localparam logic [17:0] LAST_ERA_DAY  = 18'd146096;
   localparam int unsigned YEARS_PER_CENT = 100;

   // March-based month index to its first day of year: (153 * mp + 2) / 5.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] first;
      unique case (mp)
         4'd0:    first = 9'd0;
         4'd1:    first = 9'd31;
         4'd2:    first = 9'd61;
         4'd3:    first = 9'd92;
         4'd4:    first = 9'd122;
         4'd5:    first = 9'd153;
         4'd6:    first = 9'd184;
         4'd7:    first = 9'd214;
         4'd8:    first = 9'd245;
         4'd9:    first = 9'd275;
         4'd10:   first = 9'd306;
         4'd11:   first = 9'd337;
         default: first = 9'd0;
      endcase
      return first;
   endfunction

endpackage

FILE: rtl/unix_seconds_to_civil_date.sv
// Top level of the Unix-seconds to civil date converter: a nine-stage
// pipeline built on reciprocal multiplies. Depends on ucd_pkg.
//
// Usage. A request beat (req_data: unix_seconds, fraction_ms) is taken at
// every rising edge where start is high and busy is low. busy is high only
// while reset is asserted, so outside reset a new beat can enter on every
// clock cycle. Each request produces exactly one response beat on rsp_data,
// marked by rsp_strobe for one cycle, in request order.
//
// Depth and throughput. A request passes through a nine-register path
// from its accepting edge to rsp_data. Throughput is one beat per cycle.
// The depth follows from the chain of constant divides (by 86400, 1460,
// 365, 153 and 60), each done as a registered multiply by a rounded-up
// reciprocal ahead of the logic that uses its quotient; the era split by
// 146097 is done by a compare.
//
// Reset is synchronous and clears only the valid bits, so beats in flight
// are dropped. The receiver has no way to stall the pipeline: a response
// beat must be taken in the cycle it is shown.

module unix_seconds_to_civil_date (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ucd_pkg::ucd_req_type  req_data,
   output logic                  busy,
   output logic                  rsp_strobe,
   output ucd_pkg::ucd_rsp_type  rsp_data
);

   // Time of day travels as one bundle once it is complete.
   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [9:0] millisecond;
   } tod_type;

   logic accept;
   logic [ucd_pkg::PIPE_STAGES-1:0] valid_ff, valid_in;

   assign busy   = reset;
   assign accept = start && !busy;

   // Stage 1: day count as a product, (secs >> 7) * recip(675).
   logic [50:0] s1_prod_ff, s1_prod_in;
   logic [24:0] s1_high_ff;
   logic [6:0]  s1_low_ff;
   logic [9:0]  s1_ms_ff;

   // Stage 2: day number, second of day, and the day count shifted to March 1 of year 0.
   logic [15:0] s2_days;
   logic [24:0] s2_rem;
   logic [16:0] s2_sod_ff, s2_sod_in;
   logic [19:0] s2_z_ff, s2_z_in;
   logic [9:0]  s2_ms_ff;

   // Stage 3: era split and the minute product.
   logic        s3_era5_ff, s3_era5_in;
   logic [17:0] s3_doe_ff, s3_doe_in;
   logic [30:0] s3_mprod_ff, s3_mprod_in;
   logic [16:0] s3_sod_ff;
   logic [9:0]  s3_ms_ff;

   // Stage 4: leap-day corrections, seconds and the hour product.
   logic [10:0] s4_minutes;
   logic [32:0] s4_aprod_ff, s4_aprod_in;
   logic [2:0]  s4_cent_ff, s4_cent_in;
   logic        s4_last_ff, s4_last_in;
   logic [17:0] s4_doe_ff;
   logic        s4_era5_ff;
   logic [10:0] s4_min_ff;
   logic [5:0]  s4_sec_ff, s4_sec_in;
   logic [18:0] s4_hprod_ff, s4_hprod_in;
   logic [9:0]  s4_ms_ff;

   // Stage 5: leap-free day index and the complete time of day.
   logic [6:0]  s5_quad;
   logic [17:0] s5_t_ff, s5_t_in;
   logic [17:0] s5_doe_ff;
   logic        s5_era5_ff;
   tod_type     s5_tod_ff, s5_tod_in;

   // Stage 6: year-of-era product.
   logic [36:0] s6_yprod_ff, s6_yprod_in;
   logic [17:0] s6_doe_ff;
   logic        s6_era5_ff;
   tod_type     s6_tod_ff;

   // Stage 7: year of era and day of year.
   logic [8:0]  s7_yoe_ff, s7_yoe_in;
   logic [1:0]  s7_cent;
   logic [17:0] s7_yday;
   logic [8:0]  s7_doy_ff, s7_doy_in;
   logic        s7_era5_ff;
   tod_type     s7_tod_ff;

   // Stage 8: month product and base year.
   logic [10:0] s8_num;
   logic [22:0] s8_mprod_ff, s8_mprod_in;
   logic [11:0] s8_year_ff, s8_year_in;
   logic [8:0]  s8_doy_ff;
   tod_type     s8_tod_ff;

   // Stage 9: month, day, January/February year carry, output register.
   logic [3:0]  s9_mp;
   logic [3:0]  s9_month;
   ucd_pkg::ucd_rsp_type rsp_data_ff, rsp_data_in;

   assign valid_in = {valid_ff[ucd_pkg::PIPE_STAGES-2:0], accept};

   always_comb begin
      s1_prod_in = 51'(req_data.unix_seconds[31:ucd_pkg::DAY_LOW_BITS])
                   * 51'(ucd_pkg::DAY_RECIP);

      s2_days   = 16'(s1_prod_ff >> ucd_pkg::DAY_SHIFT);
      s2_rem    = s1_high_ff - 25'(25'(s2_days) * 25'(ucd_pkg::DAY_DIV));
      s2_sod_in = {s2_rem[9:0], s1_low_ff};
      s2_z_in   = 20'(s2_days) + ucd_pkg::EPOCH_SHIFT;

      s3_era5_in  = (s2_z_ff >= ucd_pkg::ERA5_START);
      s3_doe_in   = 18'(s2_z_ff - (s3_era5_in ? ucd_pkg::ERA5_START : ucd_pkg::ERA4_START));
      s3_mprod_in = 31'(s2_sod_ff[16:2]) * 31'(ucd_pkg::MIN_RECIP);

      // doe / 1460 as (doe >> 2) / 365; doe / 36524 and doe / 146096 by compares.
      s4_aprod_in = 33'(s3_doe_ff[17:2]) * 33'(ucd_pkg::Q1460_RECIP);
      s4_cent_in  = 3'(s3_doe_ff >= 18'(ucd_pkg::CENTURY_DAYS))
                  + 3'(s3_doe_ff >= 18'(2 * ucd_pkg::CENTURY_DAYS))
                  + 3'(s3_doe_ff >= 18'(3 * ucd_pkg::CENTURY_DAYS))
                  + 3'(s3_doe_ff >= 18'(4 * ucd_pkg::CENTURY_DAYS));
      s4_last_in  = (s3_doe_ff == ucd_pkg::LAST_ERA_DAY);
      s4_minutes  = 11'(s3_mprod_ff >> ucd_pkg::MIN_SHIFT);
      s4_sec_in   = 6'(s3_sod_ff - 17'(17'(s4_minutes) * 17'(ucd_pkg::SECS_PER_MIN)));
      s4_hprod_in = 19'(s4_minutes[10:2]) * 19'(ucd_pkg::HOUR_RECIP);

      s5_quad = 7'(s4_aprod_ff >> ucd_pkg::Q1460_SHIFT);
      s5_t_in = s4_doe_ff - 18'(s5_quad) + 18'(s4_cent_ff) - 18'(s4_last_ff);
      s5_tod_in.hour        = 5'(s4_hprod_ff >> ucd_pkg::HOUR_SHIFT);
      s5_tod_in.minute      = 6'(s4_min_ff - 11'(11'(s5_tod_in.hour)
                                 * 11'(ucd_pkg::MINS_PER_HR)));
      s5_tod_in.second      = s4_sec_ff;
      s5_tod_in.millisecond = s4_ms_ff;

      s6_yprod_in = 37'(s5_t_ff) * 37'(ucd_pkg::YOE_RECIP);

      s7_yoe_in = 9'(s6_yprod_ff >> ucd_pkg::YOE_SHIFT);
      s7_cent   = 2'(s7_yoe_in >= 9'(ucd_pkg::YEARS_PER_CENT))
                + 2'(s7_yoe_in >= 9'(2 * ucd_pkg::YEARS_PER_CENT))
                + 2'(s7_yoe_in >= 9'(3 * ucd_pkg::YEARS_PER_CENT));
      s7_yday   = 18'(18'(s7_yoe_in) * 18'(ucd_pkg::DAYS_PER_YEAR))
                + 18'(s7_yoe_in >> 2) - 18'(s7_cent);
      s7_doy_in = 9'(s6_doe_ff - s7_yday);

      s8_num      = 11'(11'(s7_doy_ff) * 11'd5 + 11'd2);
      s8_mprod_in = 23'(s8_num) * 23'(ucd_pkg::MP_RECIP);
      s8_year_in  = 12'(s7_yoe_ff) + (s7_era5_ff ? ucd_pkg::ERA5_YEAR : ucd_pkg::ERA4_YEAR);

      // The March-based year rolls over in January and February.
      s9_mp    = 4'(s8_mprod_ff >> ucd_pkg::MP_SHIFT);
      s9_month = (s9_mp < 4'd10) ? s9_mp + 4'd3 : s9_mp - 4'd9;
      rsp_data_in.year        = s8_year_ff + 12'(s9_month <= 4'd2);
      rsp_data_in.month       = s9_month;
      rsp_data_in.day         = 5'(s8_doy_ff - ucd_pkg::month_start(s9_mp) + 9'd1);
      rsp_data_in.hour        = s8_tod_ff.hour;
      rsp_data_in.minute      = s8_tod_ff.minute;
      rsp_data_in.second      = s8_tod_ff.second;
      rsp_data_in.millisecond = s8_tod_ff.millisecond;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers load every cycle; the valid bits say which beats are real.
   always_ff @(posedge clock) begin
      s1_prod_ff  <= s1_prod_in;
      s1_high_ff  <= req_data.unix_seconds[31:ucd_pkg::DAY_LOW_BITS];
      s1_low_ff   <= req_data.unix_seconds[ucd_pkg::DAY_LOW_BITS-1:0];
      s1_ms_ff    <= req_data.fraction_ms;

      s2_sod_ff   <= s2_sod_in;
      s2_z_ff     <= s2_z_in;
      s2_ms_ff    <= s1_ms_ff;

      s3_era5_ff  <= s3_era5_in;
      s3_doe_ff   <= s3_doe_in;
      s3_mprod_ff <= s3_mprod_in;
      s3_sod_ff   <= s2_sod_ff;
      s3_ms_ff    <= s2_ms_ff;

      s4_aprod_ff <= s4_aprod_in;
      s4_cent_ff  <= s4_cent_in;
      s4_last_ff  <= s4_last_in;
      s4_doe_ff   <= s3_doe_ff;
      s4_era5_ff  <= s3_era5_ff;
      s4_min_ff   <= s4_minutes;
      s4_sec_ff   <= s4_sec_in;
      s4_hprod_ff <= s4_hprod_in;
      s4_ms_ff    <= s3_ms_ff;

      s5_t_ff     <= s5_t_in;
      s5_doe_ff   <= s4_doe_ff;
      s5_era5_ff  <= s4_era5_ff;
      s5_tod_ff   <= s5_tod_in;

      s6_yprod_ff <= s6_yprod_in;
      s6_doe_ff   <= s5_doe_ff;
      s6_era5_ff  <= s5_era5_ff;
      s6_tod_ff   <= s5_tod_ff;

      s7_yoe_ff   <= s7_yoe_in;
      s7_doy_ff   <= s7_doy_in;
      s7_era5_ff  <= s6_era5_ff;
      s7_tod_ff   <= s6_tod_ff;

      s8_mprod_ff <= s8_mprod_in;
      s8_year_ff  <= s8_year_in;
      s8_doy_ff   <= s7_doy_ff;
      s8_tod_ff   <= s7_tod_ff;

      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = valid_ff[ucd_pkg::PIPE_STAGES-1];
   assign rsp_data   = rsp_data_ff;

`ifndef SYNTHESIS
   a_ms_passthrough: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.millisecond == $past(req_data.fraction_ms, ucd_pkg::PIPE_STAGES))
      else $error("millisecond did not follow its request through the pipeline");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.hour < 5'd24 && rsp_data.minute < 6'd60
                      && rsp_data.second < 6'd60))
      else $error("time of day out of range");

   a_date_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.month >= 4'd1 && rsp_data.month <= 4'd12
                      && rsp_data.day >= 5'd1))
      else $error("month or day out of range");

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.year >= 12'd1970 && rsp_data.year <= 12'd2106))
      else $error("year outside the span of 32-bit Unix time");
`endif

endmodule
